>>> hdl/byte_entropy_per_packet_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte entropy block
// Shared shorthand for clocked implications with synchronous reset masking.
// ----------------------------------------------------------------------------
`ifndef BYTE_ENTROPY_PER_PACKET_TOP_ASSERT_SVH
`define BYTE_ENTROPY_PER_PACKET_TOP_ASSERT_SVH

// same-cycle implication
`define BEP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BEP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/bep_pkg.sv
// ----------------------------------------------------------------------------
// bep_pkg
// Types, widths and command/status bundles for the byte entropy block.
// ----------------------------------------------------------------------------
package bep_pkg;

   localparam int NUM_BINS             = 256;
   localparam int BIN_W                = 8;
   localparam int CNT_W                = 16;
   localparam int TGT_W                = 10;
   localparam int ENT_W                = 16;
   localparam int SUM_W                = 25;
   localparam int LOG_W                = 20;   // 4 integer bits, 16 fraction bits
   localparam int PROD_W               = CNT_W + LOG_W;
   localparam int DVD_W                = PROD_W + 1;
   localparam int DIV_W                = CNT_W + 4;
   localparam int ENTROPY_CAP          = 32768;
   localparam int TARGET_RESET         = 10;
   localparam int MAX_PACKET_BYTES_DEF = 65535;

   typedef struct packed {
      logic [BIN_W-1:0] data_byte;
      logic             last_byte;
      logic             clear_run;
   } req_type;

   typedef struct packed {
      logic [ENT_W-1:0] packet_entropy;
      logic [TGT_W-1:0] packet_number;
      logic [ENT_W-1:0] peak_entropy;
      logic [SUM_W-1:0] entropy_sum;
      logic             run_done;
   } rsp_type;

   typedef struct packed {
      logic latch;
      logic upd;
      logic drop;
      logic scan_init;
      logic rd;
      logic next;
      logic log_bin;
      logic log_len;
      logic mul_bin;
      logic mul_len;
      logic acc;
      logic sub;
      logic div_go;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic is_last;
      logic run_full;
      logic bin_live;
      logic idx_last;
      logic log_done;
      logic div_done;
   } sts_type;

endpackage

>>> hdl/bep_log2.sv
// ----------------------------------------------------------------------------
// bep_log2
// Iterative log2 in Q16: leading-one search, then one squaring round a cycle.
// ----------------------------------------------------------------------------
module bep_log2 (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bep_pkg::CNT_W-1:0] x,
   output logic                      done,
   output logic [bep_pkg::LOG_W-1:0] result
);
   import bep_pkg::*;

   localparam int Y_W = 31;

   logic [Y_W-1:0]   y_ff, y_in;
   logic [3:0]       k_ff, k_in;
   logic [15:0]      frac_ff, frac_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [3:0]       msb;
   logic [2*Y_W-1:0] sq;
   logic [31:0]      sh;

   always_comb begin
      msb = 4'd0;
      for (int i = 1; i < CNT_W; i++) begin
         if (x[i]) msb = 4'(i);
      end
   end

   assign sq = y_ff * y_ff;
   assign sh = sq[61:30];

   always_comb begin
      y_in    = y_ff;
      k_in    = k_ff;
      frac_in = frac_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         k_in    = msb;
         y_in    = Y_W'({15'd0, x} << (5'd30 - {1'b0, msb}));
         frac_in = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (sh[31]) begin
            y_in    = sh[31:1];
            frac_in = {frac_ff[14:0], 1'b1};
         end else begin
            y_in    = sh[30:0];
            frac_in = {frac_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      y_ff    <= y_in;
      k_ff    <= k_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = {k_ff, frac_ff};

endmodule

>>> hdl/bep_div.sv
// ----------------------------------------------------------------------------
// bep_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bep_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bep_pkg::DVD_W-1:0] dividend,
   input  logic [bep_pkg::DIV_W-1:0] divisor,
   output logic                      done,
   output logic [bep_pkg::DVD_W-1:0] quotient
);
   import bep_pkg::*;

   localparam int CW = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] q_ff, q_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   trial;

   assign trial = {rem_ff, q_ff[DVD_W-1]};

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         q_in   = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, dvs_ff});
            q_in   = {q_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            q_in   = {q_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DVD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

>>> hdl/bep_dp.sv
// ----------------------------------------------------------------------------
// bep_dp
// Datapath: histogram memory, packet length, run counters, log and divide.
// ----------------------------------------------------------------------------
module bep_dp #(
   parameter int MAX_PACKET_BYTES = bep_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bep_pkg::req_type          req_data,
   input  bep_pkg::cmd_type          cmd,
   output bep_pkg::sts_type          sts,
   input  logic                      csr_we,
   input  logic [bep_pkg::TGT_W-1:0] csr_wdata,
   output logic                      rsp_valid,
   output bep_pkg::rsp_type          rsp_data
);
   import bep_pkg::*;

   localparam int LEN_W = $clog2(MAX_PACKET_BYTES + 1);

   logic [CNT_W-1:0]    mem [NUM_BINS];
   logic [NUM_BINS-1:0] vld_ff;
   logic [CNT_W-1:0]    rd_ff;
   logic                rd_vld_ff;
   logic [BIN_W-1:0]    addr;
   logic [BIN_W-1:0]    idx_ff;

   req_type             req_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [TGT_W-1:0]    target_ff;
   logic [TGT_W-1:0]    done_ff;
   logic [ENT_W-1:0]    max_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [PROD_W-1:0]   s_ff, prod_ff, t_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff;

   logic [CNT_W-1:0]    n16;
   logic                room;
   logic                log_done, div_done;
   logic [LOG_W-1:0]    log_res;
   logic [DVD_W-1:0]    quot, dvd;
   logic [DIV_W-1:0]    dvs;
   logic [ENT_W-1:0]    ent;
   logic [TGT_W-1:0]    done_nx;

   assign n16  = CNT_W'(len_ff);
   assign room = len_ff < LEN_W'(MAX_PACKET_BYTES);
   assign addr = cmd.latch ? req_data.data_byte : idx_ff;

   // histogram store, registered read
   always_ff @(posedge clock) begin
      if (cmd.latch || cmd.rd) begin
         rd_ff     <= mem[addr];
         rd_vld_ff <= vld_ff[addr];
      end
      if (cmd.upd && room) begin
         mem[req_ff.data_byte] <= rd_vld_ff ? rd_ff + 16'd1 : 16'd1;
      end
   end

   bep_log2 u_log (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.log_bin || cmd.log_len),
      .x      (cmd.log_bin ? rd_ff : n16),
      .done   (log_done),
      .result (log_res)
   );

   assign dvd = {1'b0, t_ff} + (DVD_W'(n16) << 3);
   assign dvs = {n16, 4'd0};

   bep_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (div_done),
      .quotient (quot)
   );

   assign ent     = (quot > DVD_W'(ENTROPY_CAP)) ? ENT_W'(ENTROPY_CAP) : quot[ENT_W-1:0];
   assign done_nx = done_ff + 1'b1;

   always_comb begin
      rsp_in.packet_entropy = ent;
      rsp_in.packet_number  = done_nx;
      rsp_in.peak_entropy   = (ent > max_ff) ? ent : max_ff;
      rsp_in.entropy_sum    = sum_ff + SUM_W'(ent);
      rsp_in.run_done       = (done_nx == target_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) req_ff <= req_data;
      if (cmd.scan_init) begin
         idx_ff <= '0;
         s_ff   <= '0;
      end else begin
         if (cmd.next) idx_ff <= idx_ff + 1'b1;
         if (cmd.acc)  s_ff   <= s_ff + prod_ff;
      end
      if (cmd.mul_bin) prod_ff <= PROD_W'(rd_ff * log_res);
      if (cmd.mul_len) prod_ff <= PROD_W'(n16 * log_res);
      if (cmd.sub)     t_ff    <= (prod_ff > s_ff) ? prod_ff - s_ff : '0;
      if (cmd.fin)     rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         len_ff       <= '0;
         target_ff    <= TGT_W'(TARGET_RESET);
         done_ff      <= '0;
         max_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.fin;
         if (csr_we) target_ff <= csr_wdata;
         if (cmd.drop || cmd.fin) begin
            vld_ff <= '0;
            len_ff <= '0;
         end else if (cmd.upd && room) begin
            vld_ff[req_ff.data_byte] <= 1'b1;
            len_ff                   <= len_ff + 1'b1;
         end
         // run counters clear ahead of the request's own byte
         if (cmd.latch && req_data.clear_run) begin
            done_ff <= '0;
            max_ff  <= '0;
            sum_ff  <= '0;
         end else if (cmd.fin) begin
            done_ff <= done_nx;
            max_ff  <= rsp_in.peak_entropy;
            sum_ff  <= rsp_in.entropy_sum;
         end
      end
   end

   assign sts.is_last  = req_ff.last_byte;
   assign sts.run_full = done_ff >= target_ff;
   assign sts.bin_live = rd_vld_ff && (rd_ff != '0);
   assign sts.idx_last = idx_ff == BIN_W'(NUM_BINS - 1);
   assign sts.log_done = log_done;
   assign sts.div_done = div_done;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hdl/bep_ctrl.sv
// ----------------------------------------------------------------------------
// bep_ctrl
// Sequencer: byte update, end-of-packet bin walk, log, divide and result.
// ----------------------------------------------------------------------------
module bep_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bep_pkg::sts_type sts,
   output bep_pkg::cmd_type cmd
);
   import bep_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_UPD   = 4'd1;
   localparam logic [3:0] S_RD    = 4'd2;
   localparam logic [3:0] S_CHK   = 4'd3;
   localparam logic [3:0] S_LOG   = 4'd4;
   localparam logic [3:0] S_MUL   = 4'd5;
   localparam logic [3:0] S_ACC   = 4'd6;
   localparam logic [3:0] S_NLOG  = 4'd7;
   localparam logic [3:0] S_NLOGW = 4'd8;
   localparam logic [3:0] S_NMUL  = 4'd9;
   localparam logic [3:0] S_SUB   = 4'd10;
   localparam logic [3:0] S_DIV   = 4'd11;
   localparam logic [3:0] S_DIVW  = 4'd12;
   localparam logic [3:0] S_FIN   = 4'd13;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_UPD;
            end
         end
         S_UPD: begin
            cmd.upd = 1'b1;
            if (!sts.is_last) begin
               state_in = S_IDLE;
            end else if (sts.run_full) begin
               cmd.drop = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_RD;
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (sts.bin_live) begin
               cmd.log_bin = 1'b1;
               state_in    = S_LOG;
            end else if (sts.idx_last) begin
               state_in = S_NLOG;
            end else begin
               cmd.next = 1'b1;
               state_in = S_RD;
            end
         end
         S_LOG: begin
            if (sts.log_done) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_bin = 1'b1;
            state_in    = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            if (sts.idx_last) begin
               state_in = S_NLOG;
            end else begin
               cmd.next = 1'b1;
               state_in = S_RD;
            end
         end
         S_NLOG: begin
            cmd.log_len = 1'b1;
            state_in    = S_NLOGW;
         end
         S_NLOGW: begin
            if (sts.log_done) state_in = S_NMUL;
         end
         S_NMUL: begin
            cmd.mul_len = 1'b1;
            state_in    = S_SUB;
         end
         S_SUB: begin
            cmd.sub  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_go = 1'b1;
            state_in   = S_DIVW;
         end
         S_DIVW: begin
            if (sts.div_done) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

>>> hdl/byte_entropy_per_packet_top.sv
// A byte that does not end a packet is read, then the count of its bin is written.
// A final byte adds a walk of all 256 bins, unless the run is full and the packet is dropped;
// each occupied bin takes a 16-round squaring log2 unit. Then come log2(N), the subtraction,
// the 37-step divider and the result register, which loads together with the strobe.
// Throughput: one request at a time; busy stays high until the request is done.
// Reset is synchronous: histogram empty, run counters zero, packet target = 10.
// ----------------------------------------------------------------------------
// byte_entropy_per_packet_top
// Per-packet Shannon byte entropy with running maximum and sum.
// ----------------------------------------------------------------------------
module byte_entropy_per_packet_top #(
   parameter int MAX_PACKET_BYTES = bep_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  bep_pkg::req_type          req_data,
   output logic                      rsp_valid,
   output bep_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [bep_pkg::TGT_W-1:0] csr_wdata
);
   import bep_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bep_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   bep_dp #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hdl/bep_checker.sv
// ----------------------------------------------------------------------------
// bep_checker
// Port-level checks on the byte entropy block, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_entropy_per_packet_top_assert.svh"

module bep_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input bep_pkg::rsp_type rsp_data
);
   import bep_pkg::*;

   // an accepted request is always held busy for its bin update
   `BEP_ASSERT_NEXT(a_req_busy, clock, reset, start && !busy, busy, "request not held busy")
   // results are far apart: the bin walk lies between any two
   `BEP_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "back to back results")
   `BEP_ASSERT_NOW(a_ent_cap, clock, reset, rsp_valid,
      rsp_data.packet_entropy <= 16'(ENTROPY_CAP), "entropy above cap")
   `BEP_ASSERT_NOW(a_max_ge, clock, reset, rsp_valid,
      rsp_data.peak_entropy >= rsp_data.packet_entropy, "maximum below packet entropy")
   `BEP_ASSERT_NOW(a_num_nz, clock, reset, rsp_valid,
      rsp_data.packet_number != '0, "packet number zero")

endmodule

bind byte_entropy_per_packet_top bep_checker u_bep_checker (.*);
